FILE: rtl/fragment_reassembly_tracker_core_assert.svh
// Assertion macros shared by the fragment reassembly tracker RTL.
`ifndef FRAGMENT_REASSEMBLY_TRACKER_CORE_ASSERT_SVH
`define FRAGMENT_REASSEMBLY_TRACKER_CORE_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define FRT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fragment reassembly tracker: implication failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define FRT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fragment reassembly tracker: next-cycle implication failed");

`endif

FILE: rtl/frt_pkg.sv
// Types and constants shared by the fragment reassembly tracker modules.
package frt_pkg;

  localparam int DlenW   = 11;
  localparam int FrameW  = 16;
  localparam int IdxW    = 8;
  localparam int CountW  = 8;
  localparam int OffW    = 19;
  localparam int SumW    = OffW + 1;
  localparam int PlenW   = 11;
  localparam int FsizeW  = 11;
  localparam int GotW    = 9;
  localparam int TotalW  = 32;
  localparam int InDataW  = 48;
  localparam int OutDataW = 88;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 19;

  localparam int HeaderBytes  = 4;
  localparam int MaxFragments = 256;
  localparam int MapDepth     = 256;

  localparam logic [OffW-1:0]   CapReset   = 19'd262144;
  localparam logic [FsizeW-1:0] FsizeReset = 11'd1400;

  localparam logic [CfgIdxW-1:0] CfgBufferCapacity = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgFragmentSize   = 1'b1;

  typedef struct packed {
    logic              mode;
    logic              is_short;
    logic [FrameW-1:0] frame_number;
    logic [IdxW-1:0]   fragment_index;
    logic [CountW-1:0] fragment_total;
    logic [PlenW-1:0]  payload_bytes;
    logic [OffW-1:0]   offset;
  } in_item_t;

  typedef struct packed {
    logic              write_enable;
    logic              write_buffer;
    logic [OffW-1:0]   write_offset;
    logic [PlenW-1:0]  payload_bytes;
    logic              frame_complete;
    logic [OffW-1:0]   frame_bytes;
    logic              handed_off;
    logic              handoff_buffer;
    logic [TotalW-1:0] complete_count;
  } result_t;

endpackage

FILE: rtl/frt_in_stage.sv
// Input register stage: takes a request, splits the header fields and forms the write offset.
module frt_in_stage (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [frt_pkg::InDataW-1:0]  in_tdata,
  input  logic                         in_tuser,
  input  logic [frt_pkg::FsizeW-1:0]   frag_size,
  input  logic                         advance,
  output logic                         s1_valid,
  output frt_pkg::in_item_t            s1_item
);
  import frt_pkg::*;

  logic     valid_r, valid_nxt;
  logic     accept;
  in_item_t item_r, item_nxt;
  logic [DlenW-1:0] dlen;

  always_comb begin
    in_tready = !valid_r || advance;
    accept    = in_tvalid && in_tready;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
    dlen                    = in_tdata[10:0];
    item_nxt.mode           = in_tuser;
    item_nxt.is_short       = dlen < DlenW'(HeaderBytes);
    item_nxt.frame_number   = in_tdata[26:11];
    item_nxt.fragment_index = in_tdata[34:27];
    item_nxt.fragment_total = in_tdata[42:35];
    item_nxt.payload_bytes  = PlenW'(dlen - DlenW'(HeaderBytes));
    item_nxt.offset         = OffW'(in_tdata[34:27]) * OffW'(frag_size);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

FILE: rtl/frt_track.sv
// Frame tracking state and the combinational update that forms each result.
module frt_track (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     fire,
  input  frt_pkg::in_item_t        item,
  input  logic [frt_pkg::OffW-1:0] buf_cap,
  output frt_pkg::result_t         res
);
  import frt_pkg::*;

  logic                tracking_r, tracking_nxt;
  logic [FrameW-1:0]   cur_frame_r, cur_frame_nxt;
  logic [CountW-1:0]   needed_r, needed_nxt;
  logic [GotW-1:0]     got_r, got_nxt;
  logic [OffW-1:0]     end_r, end_nxt;
  logic [MapDepth-1:0] seen_r, seen_nxt;
  logic                fill_r, fill_nxt;
  logic                busy_r, busy_nxt;
  logic [TotalW-1:0]   total_r, total_nxt;
  logic                restart;
  logic                in_range;
  logic                fits;
  logic [SumW-1:0]     end_pos;

  always_comb begin
    tracking_nxt  = tracking_r;
    cur_frame_nxt = cur_frame_r;
    needed_nxt    = needed_r;
    got_nxt       = got_r;
    end_nxt       = end_r;
    seen_nxt      = seen_r;
    fill_nxt      = fill_r;
    busy_nxt      = busy_r;
    total_nxt     = total_r;
    restart       = !tracking_r || (item.frame_number != cur_frame_r);
    in_range      = GotW'(item.fragment_index) < GotW'(MaxFragments);
    end_pos       = SumW'(item.offset) + SumW'(item.payload_bytes);
    fits          = end_pos <= SumW'(buf_cap);
    res           = '0;

    if (item.mode) begin
      busy_nxt = 1'b0;
    end else if (!item.is_short && (item.fragment_total != '0)) begin
      if (restart) begin
        tracking_nxt  = 1'b1;
        cur_frame_nxt = item.frame_number;
        needed_nxt    = item.fragment_total;
        got_nxt       = '0;
        end_nxt       = '0;
        seen_nxt      = '0;
      end
      if (in_range && fits) begin
        if (!seen_nxt[item.fragment_index]) begin
          seen_nxt[item.fragment_index] = 1'b1;
          got_nxt                       = got_nxt + 1'b1;
          if (end_pos > SumW'(end_nxt)) begin
            end_nxt = end_pos[OffW-1:0];
          end
          res.write_enable  = 1'b1;
          res.write_buffer  = fill_r;
          res.write_offset  = item.offset;
          res.payload_bytes = item.payload_bytes;
        end
        if ((got_nxt >= GotW'(needed_nxt)) && (end_nxt != '0)) begin
          total_nxt          = total_r + 1'b1;
          res.frame_complete = 1'b1;
          res.frame_bytes    = end_nxt;
          if (!busy_r) begin
            res.handed_off     = 1'b1;
            res.handoff_buffer = fill_r;
            busy_nxt           = 1'b1;
            fill_nxt           = !fill_r;
          end
          tracking_nxt = 1'b0;
        end
      end
    end
    res.complete_count = total_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tracking_r  <= 1'b0;
      cur_frame_r <= '0;
      needed_r    <= '0;
      got_r       <= '0;
      end_r       <= '0;
      seen_r      <= '0;
      fill_r      <= 1'b0;
      busy_r      <= 1'b0;
      total_r     <= '0;
    end else if (fire) begin
      tracking_r  <= tracking_nxt;
      cur_frame_r <= cur_frame_nxt;
      needed_r    <= needed_nxt;
      got_r       <= got_nxt;
      end_r       <= end_nxt;
      seen_r      <= seen_nxt;
      fill_r      <= fill_nxt;
      busy_r      <= busy_nxt;
      total_r     <= total_nxt;
    end
  end

endmodule

FILE: rtl/frt_out_reg.sv
// Result register: holds one result until the downstream side takes it.
module frt_out_reg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          s1_valid,
  input  frt_pkg::result_t              res,
  output logic                          advance,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [frt_pkg::OutDataW-1:0]  out_tdata
);
  import frt_pkg::*;

  logic    valid_r, valid_nxt;
  logic    load;
  result_t res_r;

  always_comb begin
    advance   = !valid_r || out_tready;
    load      = advance && s1_valid;
    valid_nxt = advance ? s1_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {2'b00, res_r.complete_count, res_r.handoff_buffer, res_r.handed_off,
                       res_r.frame_bytes, res_r.frame_complete, res_r.payload_bytes,
                       res_r.write_offset, res_r.write_buffer, res_r.write_enable};

endmodule

FILE: rtl/fragment_reassembly_tracker_core.sv
// Top level of the fragment reassembly tracker: configuration registers and the two-stage path.
//
// Each request is either a datagram header (tuser low) or a note that the decoder is free
// (tuser high), and each request yields exactly one result. The block takes one request per
// clock cycle for as long as results are taken. The result of an accepted request passes through
// the input register, then the result register, from which it is presented. All tracking state,
// including the 256-entry fragment map, is updated combinationally between those registers, so
// consecutive requests see each other's effect with no bubble. The fragment map is cleared at
// once when a new frame starts, and no clearing pass runs after reset. Configuration writes
// must only be made while no request is in flight.
module fragment_reassembly_tracker_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [frt_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [frt_pkg::CfgDataW-1:0]  cfg_data,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // datagram_length[10:0], frame_number[26:11], fragment_index[34:27],
  // fragment_total[42:35], zero pad[47:43]
  input  logic [frt_pkg::InDataW-1:0]   in_tdata,
  // mode[0]
  input  logic                          in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // write_enable[0], write_buffer[1], write_offset[20:2], payload_bytes[31:21],
  // frame_complete[32], frame_bytes[51:33], handed_off[52], handoff_buffer[53],
  // complete_count[85:54], zero pad[87:86]
  output logic [frt_pkg::OutDataW-1:0]  out_tdata
);
  import frt_pkg::*;

  logic [OffW-1:0]   cap_r;
  logic [FsizeW-1:0] fsize_r;
  logic              advance;
  logic              s1_valid;
  logic              fire;
  in_item_t          s1_item;
  result_t           res_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CapReset;
      fsize_r <= FsizeReset;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgBufferCapacity: cap_r   <= cfg_data[OffW-1:0];
        CfgFragmentSize:   fsize_r <= cfg_data[FsizeW-1:0];
        default: ;
      endcase
    end
  end

  assign fire = advance && s1_valid;

  frt_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .frag_size (fsize_r),
    .advance   (advance),
    .s1_valid  (s1_valid),
    .s1_item   (s1_item)
  );

  frt_track u_track (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .item    (s1_item),
    .buf_cap (cap_r),
    .res     (res_w)
  );

  frt_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_valid   (s1_valid),
    .res        (res_w),
    .advance    (advance),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

`include "fragment_reassembly_tracker_core_assert.svh"

  `FRT_ASSERT_IMP(a_hand_needs_done, clk, rst_n, out_tvalid && out_tdata[52], out_tdata[32])
  `FRT_ASSERT_IMP(a_done_has_bytes, clk, rst_n, out_tvalid && out_tdata[32],
                  out_tdata[51:33] != '0)
  `FRT_ASSERT_IMP(a_write_in_capacity, clk, rst_n, out_tvalid && out_tdata[0],
                  (SumW'(out_tdata[20:2]) + SumW'(out_tdata[31:21])) <= SumW'(cap_r))
  `FRT_ASSERT_NXT(a_no_double_hand, clk, rst_n, fire && res_w.handed_off,
                  !(fire && res_w.handed_off))

endmodule
